// File: rtl/core/sws_pkg.sv
// sws_pkg: shared types and constants for the substring window search block.
// Used by sws_cell, substring_window_search, sws_scoreboard and the testbench; no dependencies.
`timescale 1ns / 1ps

package sws_pkg;

    // Default number of pattern bytes (cells in the compare chain)
    localparam int MAX_PATTERN_BYTES_DEF = 8;

    // Fixed field widths
    localparam int PATTERN_W  = 64;
    localparam int PLEN_W     = 4;
    localparam int OFFSET_W   = 15;
    localparam int LEN_W      = 16;
    localparam int POS_W      = 15;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLARED_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT    = 3'd5;

    // Pattern settings fanned out to every cell
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [PLEN_W-1:0]    plen;
    } t_cell_cfg;

    // One result item
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

// File: rtl/core/sws_cell.sv
// sws_cell: one stage of the byte history chain with its pattern compare.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_cell
    import sws_pkg::*;
#(
    parameter int AGE = 0
) (
    input  logic      i_clk,
    input  logic      i_shift,
    input  logic [7:0] i_byte,    // byte of age AGE for the current request
    input  t_cell_cfg i_cfg,
    output logic [7:0] o_byte,    // same byte, one age older after the shift
    output logic      o_eq
);

    logic [7:0]        r_byte;
    logic [PLEN_W-1:0] idx;
    logic [7:0]        pat_byte;

    // Byte of age AGE lines up with pattern byte plen-1-AGE
    assign idx      = i_cfg.plen - PLEN_W'(AGE) - PLEN_W'(1);
    assign pat_byte = i_cfg.pattern[{idx[2:0], 3'b000} +: 8];
    assign o_eq     = (i_cfg.plen <= PLEN_W'(AGE)) || (i_byte == pat_byte);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: rtl/core/substring_window_search.sv
// substring_window_search: streaming first-occurrence substring search, top level.
// Depends on sws_pkg and sws_cell.
`timescale 1ns / 1ps
//
// Usage
//   Input stream : s_axis_* carries the main string one byte per request,
//                  s_axis_tlast on the final byte. A zero byte ends the search.
//   Output stream: m_axis_* carries exactly one result per string:
//                  tuser = found, tdata = match position (0 when not found).
//   Config port  : i_cfg_wr_en / i_cfg_index / i_cfg_data, written while idle.
//                  0 pattern, 1 pattern length, 2 start offset, 3 declared
//                  length, 4 window enable, 5 window count; others ignored.
// Throughput: one byte per cycle while s_axis_tready is high. The byte history sits
//   in a chain of MAX_PATTERN_BYTES cells, each comparing its byte with the aligned
//   pattern byte, so the full match is decided in the cycle the byte arrives.
// Output: the result is registered, in the output register or, while that still
//   holds an untaken result, in the skid entry.
// Stall: a result register plus one skid entry; s_axis_tready drops only when
//   both hold results, and rises once the receiver takes one.
// Reset: synchronous, active low; clears the per-string state, the result
//   queue and loads the register defaults. No clearing pass is needed.

module substring_window_search
    import sws_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [14:0] match_position, [15] zero
    output logic                 m_axis_tuser,   // found
    // Configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PATTERN_W-1:0] i_cfg_data
);

    localparam int BSO_W = $clog2(MAX_PATTERN_BYTES + 1);

    // Configuration registers
    logic [PATTERN_W-1:0] r_pattern;
    logic [PLEN_W-1:0]    r_plen;
    logic [OFFSET_W-1:0]  r_start;
    logic [LEN_W-1:0]     r_decl_len;
    logic                 r_win_en;
    logic [LEN_W-1:0]     r_win_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_plen     <= '0;
            r_start    <= '0;
            r_decl_len <= '1;
            r_win_en   <= 1'b0;
            r_win_cnt  <= '1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PATTERN:         r_pattern  <= i_cfg_data;
                CFG_PATTERN_LENGTH:  r_plen     <= i_cfg_data[PLEN_W-1:0];
                CFG_START_OFFSET:    r_start    <= i_cfg_data[OFFSET_W-1:0];
                CFG_DECLARED_LENGTH: r_decl_len <= i_cfg_data[LEN_W-1:0];
                CFG_WINDOW_ENABLE:   r_win_en   <= i_cfg_data[0];
                CFG_WINDOW_COUNT:    r_win_cnt  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-string state
    logic [LEN_W-1:0] r_pos, n_pos;        // position of the next byte, saturating
    logic [BSO_W-1:0] r_bso, n_bso;        // bytes seen at or after start offset
    logic             r_done, n_done;      // result for this string already given

    // Result queue: output register plus skid entry
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;

    logic accept;
    assign s_axis_tready = !r_skid_v;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Cell chain: cell k sees the byte of age k, cell 0 the incoming byte
    t_cell_cfg                    cell_cfg;
    logic [7:0]                   chain [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] eq;

    assign cell_cfg.pattern = r_pattern;
    assign cell_cfg.plen    = r_plen;
    assign chain[0]         = s_axis_tdata;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        if (k < MAX_PATTERN_BYTES - 1) begin : g_mid
            sws_cell #(.AGE(k)) u_cell (
                .i_clk  (i_clk),
                .i_shift(accept),
                .i_byte (chain[k]),
                .i_cfg  (cell_cfg),
                .o_byte (chain[k+1]),
                .o_eq   (eq[k])
            );
        end else begin : g_end
            sws_cell #(.AGE(k)) u_cell (
                .i_clk  (i_clk),
                .i_shift(accept),
                .i_byte (chain[k]),
                .i_cfg  (cell_cfg),
                .o_byte (),
                .o_eq   (eq[k])
            );
        end
    end

    // Upfront checks, repeated on every byte until the search concludes
    logic             chk_fail, fail;
    logic [LEN_W:0]   so_plus_len, so_plus_win, q_plus1;
    logic [LEN_W:0]   cand;
    logic             enough, pos_big, win_out, match, done, hit;

    assign so_plus_len = (LEN_W+1)'(r_start) + (LEN_W+1)'(r_plen);
    assign chk_fail    = (r_plen == '0)
                      || (r_plen > PLEN_W'(MAX_PATTERN_BYTES))
                      || (so_plus_len > (LEN_W+1)'(r_decl_len))
                      || (r_win_en && ((LEN_W)'(r_plen) > r_win_cnt));
    assign fail        = chk_fail || (s_axis_tdata == 8'd0);

    always_comb begin
        n_bso = r_bso;
        if ((r_pos >= LEN_W'(r_start)) && (r_bso < BSO_W'(MAX_PATTERN_BYTES))) begin
            n_bso = r_bso + BSO_W'(1);
        end
    end

    // Candidate start q+1-plen; the match would end at q+1
    assign q_plus1     = (LEN_W+1)'(r_pos) + (LEN_W+1)'(1);
    assign cand        = q_plus1 - (LEN_W+1)'(r_plen);
    assign so_plus_win = (LEN_W+1)'(r_start) + (LEN_W+1)'(r_win_cnt);
    assign enough      = (PLEN_W'(n_bso) >= r_plen);
    assign pos_big     = cand[LEN_W-1];
    assign win_out     = r_win_en && (q_plus1 > so_plus_win);
    assign match       = &eq;

    assign hit  = !fail && enough && !pos_big && !win_out && match;
    assign done = fail || (enough && (pos_big || win_out || match));

    logic    emit;
    t_result res;
    assign emit         = accept && !r_done && (done || s_axis_tlast);
    assign res.found    = hit;
    assign res.position = hit ? cand[POS_W-1:0] : '0;

    // Per-string state update
    always_comb begin
        n_pos  = r_pos;
        n_done = r_done;
        if (accept) begin
            if (!r_done) begin
                if (!fail && (r_pos != '1)) begin
                    n_pos = r_pos + LEN_W'(1);
                end
                if (done) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bso  <= '0;
            r_done <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            r_pos  <= '0;
            r_bso  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_done <= n_done;
            if (accept && !r_done && !fail) begin
                r_bso <= n_bso;
            end
        end
    end

    // Result queue
    logic pop;
    assign pop = r_out_v && m_axis_tready;

    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            if (pop) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (emit) begin
            if (!r_out_v || pop) begin
                n_out   = res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = res;
                n_skid_v = 1'b1;
            end
        end else if (pop) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.found;
    assign m_axis_tdata  = {1'b0, r_out.position};

endmodule

// File: rtl/core/sws_checker.sv
// sws_checker: port-level assertions for substring_window_search, with its bind.
// Standalone; attached to the top level by the bind below.
`timescale 1ns / 1ps

module sws_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [15:0]          m_axis_tdata,
    input logic                 m_axis_tuser
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // Input back-pressure only when the output already holds a result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // A not-found result carries position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
        else $error("not-found result with nonzero position");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind substring_window_search sws_checker u_sws_checker (.*);

// File: tb/sws_checker.sv
`timescale 1ns / 1ps
// sws_scoreboard: watches the search block's streams and config port, predicts the
// outcome of every string and compares it with each returned result. Needs sws_pkg.

module sws_scoreboard
    import sws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [7:0]           i_req_byte,
    input  logic                 i_req_last,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [15:0]          i_res_data,   // [14:0] match_position, [15] zero
    input  logic                 i_res_found,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PATTERN_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int unsigned HIST_BYTES = MAX_PATTERN_BYTES_DEF;
    localparam int unsigned POS_LIMIT  = 32767;

    // register copies
    logic [PATTERN_W-1:0] pattern_q;
    logic [PLEN_W-1:0]    plen_q;
    logic [OFFSET_W-1:0]  offset_q;
    logic [LEN_W-1:0]     decl_len_q;
    logic                 win_en_q;
    logic [LEN_W-1:0]     win_cnt_q;

    // per-string search state
    logic [63:0]          history;
    int unsigned          str_pos;
    int unsigned          seen_cnt;
    bit                   concluded;

    t_result              search_outcomes[$];
    int                   fails = 0;

    assign o_fail_count = fails;

    function automatic void restart_string();
        history   = '0;
        str_pos   = 0;
        seen_cnt  = 0;
        concluded = 1'b0;
    endfunction

    function automatic bit bounds_fail();
        int unsigned pl;
        pl = 32'(plen_q);
        if (pl == 0 || pl > HIST_BYTES) return 1'b1;
        if (int'(offset_q) + pl > decl_len_q) return 1'b1;
        if (win_en_q && pl > win_cnt_q) return 1'b1;
        return 1'b0;
    endfunction

    // one accepted byte of the main string
    function automatic void advance_search(input logic [7:0] b, input logic last);
        bit          done;
        bit          hit;
        int unsigned pl;
        int unsigned q;
        int unsigned p;
        logic [63:0] cand;
        logic [63:0] pat;
        t_result     r;
        done = 1'b0;
        hit  = 1'b0;
        p    = 0;
        pl   = 32'(plen_q);
        if (concluded) begin
            // already answered: only the last byte matters, it rearms
            if (last) restart_string();
        end else begin
            if (bounds_fail() || b == 8'h00) begin
                done = 1'b1;
            end else begin
                q = str_pos;
                history = {b, history[63:8]};
                if (q >= offset_q && seen_cnt < HIST_BYTES) seen_cnt++;
                if (seen_cnt >= pl) begin
                    p = q + 1 - pl;
                    if (p > POS_LIMIT) begin
                        done = 1'b1;
                    end else if (win_en_q && p + pl > int'(offset_q) + int'(win_cnt_q)) begin
                        done = 1'b1;
                    end else begin
                        cand = history >> (64 - 8 * pl);
                        pat  = pattern_q;
                        if (pl < HIST_BYTES) pat &= (64'd1 << (8 * pl)) - 64'd1;
                        if (cand == pat) begin
                            done = 1'b1;
                            hit  = 1'b1;
                        end
                    end
                end
                if (str_pos < 32'hFFFF) str_pos++;
            end
            if (done || last) begin
                r.found    = hit;
                r.position = hit ? p[POS_W-1:0] : '0;
                search_outcomes.push_back(r);
                concluded = 1'b1;
            end
            if (last) restart_string();
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            pattern_q  = '0;
            plen_q     = '0;
            offset_q   = '0;
            decl_len_q = '1;
            win_en_q   = 1'b0;
            win_cnt_q  = '1;
            restart_string();
            search_outcomes.delete();
            o_pending  <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PATTERN:         pattern_q  = i_cfg_data;
                    CFG_PATTERN_LENGTH:  plen_q     = i_cfg_data[PLEN_W-1:0];
                    CFG_START_OFFSET:    offset_q   = i_cfg_data[OFFSET_W-1:0];
                    CFG_DECLARED_LENGTH: decl_len_q = i_cfg_data[LEN_W-1:0];
                    CFG_WINDOW_ENABLE:   win_en_q   = i_cfg_data[0];
                    CFG_WINDOW_COUNT:    win_cnt_q  = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (search_outcomes.size() == 0) begin
                    $display("%0t: result with nothing outstanding: found=%0b pos=%0d",
                             $time, i_res_found, i_res_data[POS_W-1:0]);
                    fails++;
                end else begin
                    exp_res = search_outcomes.pop_front();
                    if (i_res_found !== exp_res.found ||
                        i_res_data !== {1'b0, exp_res.position}) begin
                        $display("%0t: mismatch: expected found=%0b pos=%0d, actual found=%0b data=%h",
                                 $time, exp_res.found, exp_res.position, i_res_found,
                                 i_res_data);
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) advance_search(i_req_byte, i_req_last);
            o_pending <= search_outcomes.size();
        end
    end

endmodule

// File: tb/substring_window_search_tb.sv
`timescale 1ns / 1ps
// substring_window_search_tb: drives strings and register settings into the search
// block and gives the verdict. Needs sws_pkg, sws_scoreboard and the block's RTL.

module substring_window_search_tb;
    import sws_pkg::*;

    // unmapped register indexes, written now and then to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    // cycles with no request, result or register write before giving up
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BYTES = 1700;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PATTERN_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int snd_idle_pct = 20;
    int rcv_idle_pct = 80;
    int bytes_sent = 0;
    int stall_cycles = 0;

    // current settings, kept so that strings can be built around the pattern
    logic [PATTERN_W-1:0] cur_pattern;
    logic [PLEN_W-1:0]    cur_plen;
    logic [OFFSET_W-1:0]  cur_offset;
    logic [7:0]           str_bytes [0:127];

    always #2 i_clk = ~i_clk;

    substring_window_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),    // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [14:0] match_position, [15] zero
        .m_axis_tuser  (m_axis_tuser),    // found
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sws_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_byte   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_found  (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure, one fresh draw per cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // watchdog: any request, result or register write restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one request; valid stays up straight into the next byte when no gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // sender drops valid and holds off until every predicted result has been taken,
    // then waits on before returning, in case the last byte caused nothing
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // full register load, only ever between strings with the block idle
    task automatic load_search(input logic [PATTERN_W-1:0] pat, input logic [PLEN_W-1:0] plen,
                               input logic [OFFSET_W-1:0] off, input logic [LEN_W-1:0] decl,
                               input logic wen, input logic [LEN_W-1:0] wcnt);
        wait_results_drained();
        cfg_write(CFG_PATTERN, pat);
        cfg_write(CFG_PATTERN_LENGTH, 64'(plen));
        cfg_write(CFG_START_OFFSET, 64'(off));
        cfg_write(CFG_DECLARED_LENGTH, 64'(decl));
        cfg_write(CFG_WINDOW_ENABLE, 64'(wen));
        cfg_write(CFG_WINDOW_COUNT, 64'(wcnt));
        if ($urandom_range(9) == 0)
            cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, {$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_pattern = pat;
        cur_plen    = plen;
        cur_offset  = off;
    endtask

    task automatic random_setup();
        logic [PATTERN_W-1:0] pat;
        logic [PLEN_W-1:0]    plen;
        logic [OFFSET_W-1:0]  off;
        logic [LEN_W-1:0]     decl;
        logic [LEN_W-1:0]     wcnt;
        int                   r;
        int                   k;
        for (k = 0; k < 8; k++) pat[8*k +: 8] = 8'($urandom_range(255, 1));
        r = $urandom_range(99);
        if (r < 2) pat = '0;
        else if (r < 4) pat = '1;
        r = $urandom_range(99);
        if (r < 6) plen = '0;
        else if (r < 12) plen = PLEN_W'($urandom_range(15, 9));
        else plen = PLEN_W'($urandom_range(8, 1));
        r = $urandom_range(99);
        if (r < 60) off = '0;
        else if (r < 90) off = OFFSET_W'($urandom_range(12, 1));
        else off = OFFSET_W'($urandom_range(32767, 0));
        r = $urandom_range(99);
        if (r < 80) decl = '1;
        else if (r < 90) decl = LEN_W'($urandom_range(20, 0));
        else decl = LEN_W'($urandom_range(65535, 0));
        r = $urandom_range(99);
        if (r < 40) wcnt = LEN_W'($urandom_range(24, 0));
        else if (r < 70) wcnt = '1;
        else wcnt = LEN_W'($urandom_range(65535, 0));
        load_search(pat, plen, off, decl, 1'($urandom_range(1)), wcnt);
    endtask

    // pattern bytes mixed with random bytes, often with one whole copy planted
    task automatic send_random_string(input int len);
        int          k;
        int          pl;
        int          lo;
        int          start_at;
        logic [7:0]  b;
        pl = (cur_plen >= 1 && cur_plen <= 8) ? int'(cur_plen) : 1;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 45) b = cur_pattern[8*$urandom_range(pl - 1, 0) +: 8];
            else b = 8'($urandom_range(255, 1));
            if (b == 8'h00) b = 8'($urandom_range(255, 1));
            if ($urandom_range(199) == 0) b = 8'h00;    // rare terminator
            str_bytes[k] = b;
        end
        if (len >= pl && $urandom_range(99) < 55) begin
            lo = (cur_offset + pl <= len && $urandom_range(99) < 70) ? int'(cur_offset) : 0;
            start_at = $urandom_range(len - pl, lo);
            for (k = 0; k < pl; k++) str_bytes[start_at + k] = cur_pattern[8*k +: 8];
        end
        for (k = 0; k < len; k++) send_byte(str_bytes[k], k == len - 1);
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct, input int upto);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        random_setup();
        while (bytes_sent < upto) begin
            if ($urandom_range(99) < 35) random_setup();
            if ($urandom_range(9) == 0) send_random_string($urandom_range(80, 30));
            else send_random_string($urandom_range(30, 1));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset settings: empty pattern concludes on the first byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // overlong pattern
        load_search('0, 4'd15, '0, '1, 1'b0, '1);
        send_byte(8'h41, 1'b1);
        // all-ones pattern masked to two bytes, match on the last byte at 1
        load_search('1, 4'd2, '0, '1, 1'b0, '1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // upfront check fails against a zero declared length
        load_search('1, 4'd2, '0, '0, 1'b0, '1);
        send_byte(8'h10, 1'b1);
        // window of zero bytes cannot hold the pattern
        load_search('1, 4'd2, '0, '1, 1'b1, '0);
        send_byte(8'h20, 1'b1);
        // "ab" from offset 1 in a 3-byte window: fits once, then runs past it
        load_search(64'h6261, 4'd2, 15'd1, '1, 1'b1, 16'd3);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        // zero byte ends the search; the rest of the string is ignored
        load_search(64'h6261, 4'd2, '0, '1, 1'b0, '1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        // string ends before anything could match
        send_byte(8'h63, 1'b1);

        // --- random, three back-pressure regimes ---
        random_phase(20, 80, bytes_sent + RANDOM_BYTES / 3);
        random_phase(80, 20, bytes_sent + RANDOM_BYTES / 3);
        random_phase(0, 0, bytes_sent + RANDOM_BYTES / 3);

        wait_results_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: substring_window_search.f
rtl/core/sws_pkg.sv
rtl/core/sws_cell.sv
rtl/core/substring_window_search.sv
rtl/core/sws_checker.sv
tb/sws_checker.sv
tb/substring_window_search_tb.sv
